>>> design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stuffed frame receiver
// Byte classes, result kinds and the unstuffing table used by the front part
// and the frame engine.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // Result kinds.
   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_FRAME_OK = 3'd1;
   localparam logic [2:0] KIND_BAD_HDR  = 3'd2;
   localparam logic [2:0] KIND_CSUM_ERR = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd5;

   typedef enum logic [1:0] {
      CLS_DATA    = 2'd0,
      CLS_FLAG    = 2'd1,
      CLS_ESC     = 2'd2,
      CLS_TIMEOUT = 2'd3
   } class_type;

   // One classified line event as it waits in the queue.
   typedef struct packed {
      class_type  cls;
      logic [7:0] raw;
      logic [7:0] unstuffed;
   } entry_type;

   function automatic logic [7:0] unstuff(input logic [7:0] b);
      logic [7:0] v;
      case (b)
         8'h31:   v = 8'h11;
         8'h33:   v = 8'h13;
         8'h5D:   v = 8'h7D;
         8'h5E:   v = 8'h7E;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

>>> design/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: input classifier
// Sorts each incoming transaction into timeout, flag, escape or data and
// precomputes the unstuffed value of the byte.
// ----------------------------------------------------------------------------
module sfr_front (
   input  logic              opcode,
   input  logic [7:0]        rx_byte,
   output sfr_pkg::entry_type entry
);
   import sfr_pkg::*;

   always_comb begin
      entry.raw       = rx_byte;
      entry.unstuffed = unstuff(rx_byte);
      if (opcode == OP_TIMEOUT) begin
         entry.cls = CLS_TIMEOUT;
      end else if (rx_byte == FLAG_BYTE) begin
         entry.cls = CLS_FLAG;
      end else if (rx_byte == ESC_BYTE) begin
         entry.cls = CLS_ESC;
      end else begin
         entry.cls = CLS_DATA;
      end
   end

endmodule

>>> design/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: two-entry queue
// Decouples the classifier from the frame engine so that either side can
// stall without stopping the other.
// ----------------------------------------------------------------------------
module sfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfr_pkg::entry_type push_entry,
   output logic               can_push,
   input  logic               pop,
   output logic               head_valid,
   output sfr_pkg::entry_type head_entry
);
   import sfr_pkg::*;

   entry_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

>>> design/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: frame engine
// Tracks frame state, unstuffs, delays data bytes by one, keeps the running
// sum and length, and registers one result for the output channel.
// ----------------------------------------------------------------------------
module sfr_back #(
   parameter int MAX_FRAME = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  sfr_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_data_byte,
   output logic [7:0]         rsp_position,
   output logic [7:0]         rsp_device_status,
   output logic [7:0]         rsp_frame_length
);
   import sfr_pkg::*;

   localparam logic [8:0] MAX_FRAME_W = 9'(MAX_FRAME);

   logic       in_frame_ff, in_frame_in;
   logic       esc_ff, esc_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] status_ff, status_in;

   logic       out_valid_ff, out_valid_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] dstat_ff, dstat_in;
   logic [7:0] len_ff, len_in;

   logic       emit;
   logic       do_store;
   logic [7:0] store_val;
   logic [7:0] count_inc;

   assign pop       = head_valid && (!out_valid_ff || rsp_ready);
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      emit          = 1'b0;
      kind_in       = kind_ff;
      data_in       = 8'd0;
      pos_in        = 8'd0;
      dstat_in      = 8'd0;
      len_in        = 8'd0;
      do_store      = 1'b0;
      store_val     = head_entry.raw;

      if (pop) begin
         if (head_entry.cls == CLS_TIMEOUT) begin
            in_frame_in = 1'b0;
            emit        = 1'b1;
            kind_in     = KIND_TIMEOUT;
         end else if (!in_frame_ff) begin
            if (head_entry.cls == CLS_FLAG) begin
               in_frame_in = 1'b1;
            end else begin
               emit    = 1'b1;
               kind_in = KIND_BAD_HDR;
            end
         end else if (head_entry.cls == CLS_ESC) begin
            esc_in = 1'b1;
         end else if (esc_ff) begin
            esc_in    = 1'b0;
            do_store  = 1'b1;
            store_val = head_entry.unstuffed;
         end else if (head_entry.cls == CLS_FLAG) begin
            // A flag right after the opening flag just restarts reception.
            if (count_ff != 8'd0) begin
               emit        = 1'b1;
               kind_in     = (held_ff == ~sum_ff) ? KIND_FRAME_OK : KIND_CSUM_ERR;
               dstat_in    = (count_ff >= 8'd4) ? status_ff : 8'd0;
               len_in      = count_ff;
               in_frame_in = 1'b0;
            end
         end else begin
            do_store = 1'b1;
         end

         if (do_store) begin
            if ({1'b0, count_ff} + 9'd1 >= MAX_FRAME_W) begin
               emit        = 1'b1;
               kind_in     = KIND_OVERFLOW;
               in_frame_in = 1'b0;
            end else begin
               if (held_valid_ff) begin
                  emit    = 1'b1;
                  kind_in = KIND_DATA;
                  data_in = held_ff;
                  pos_in  = count_ff;
                  sum_in  = sum_ff + held_ff;
               end
               held_in       = store_val;
               held_valid_in = 1'b1;
               count_in      = count_inc;
               if (count_inc == 8'd3) begin
                  status_in = store_val;
               end
            end
         end

         // Every frame boundary, restart or abort clears the frame context.
         if (!do_store && head_entry.cls != CLS_ESC && in_frame_ff == 1'b0 ?
             head_entry.cls == CLS_FLAG || head_entry.cls == CLS_TIMEOUT :
             !do_store && (head_entry.cls == CLS_FLAG || head_entry.cls == CLS_TIMEOUT)
             && !(esc_ff && head_entry.cls != CLS_TIMEOUT)) begin
            esc_in        = 1'b0;
            held_valid_in = 1'b0;
            held_in       = 8'd0;
            sum_in        = 8'd0;
            count_in      = 8'd0;
            status_in     = 8'd0;
         end
         if (do_store && kind_in == KIND_OVERFLOW && emit) begin
            esc_in        = 1'b0;
            held_valid_in = 1'b0;
            held_in       = 8'd0;
            sum_in        = 8'd0;
            count_in      = 8'd0;
            status_in     = 8'd0;
         end
      end

      if (pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         esc_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         held_ff       <= 8'd0;
         sum_ff        <= 8'd0;
         count_ff      <= 8'd0;
         status_ff     <= 8'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         esc_ff        <= esc_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff  <= kind_in;
         data_ff  <= data_in;
         pos_ff   <= pos_in;
         dstat_ff <= dstat_in;
         len_ff   <= len_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_position      = pos_ff;
   assign rsp_device_status = dstat_ff;
   assign rsp_frame_length  = len_ff;

   a_held_in_frame: assert property (@(posedge clock) disable iff (reset)
      (held_valid_ff || esc_ff) |-> in_frame_ff)
      else $error("frame context alive outside a frame");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < MAX_FRAME_W) else $error("byte count beyond frame limit");
   a_held_count: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff == (count_ff != 8'd0)) else $error("held byte and count disagree");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && !pop || out_valid_ff))
      else $error("pending result dropped");

endmodule

>>> design/stuffed_frame_receiver_top.sv
// Path: an accepted transaction is written into the queue; its result, if any,
//    is then held in the result register and shown on the rsp side.
// Throughput: one transaction per cycle while the rsp side accepts; a stalled
//    result register stops pops, fills the two-entry queue, then drops req_tready.
// Reset: synchronous; clears the queue, the frame state and the result valid.
//    No clearing pass; the block accepts transactions right after reset.
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top: byte-stuffed frame receiver
// Receives line bytes and timeout events, unstuffs frames, checks the sum and
// reports data bytes and frame results on a stream channel.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top #(
   parameter int MAX_FRAME = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] data_byte, [15:8] position,
                                    // [23:16] device_status, [31:24] frame_length
   output logic [2:0]  rsp_tuser    // [2:0] kind
);
   import sfr_pkg::*;

   entry_type  front_entry;
   entry_type  head_entry;
   logic       can_push;
   logic       head_valid;
   logic       pop;
   logic [2:0] kind;
   logic [7:0] data_byte, position, device_status, frame_length;

   assign req_tready = can_push;

   sfr_front u_front (
      .opcode  (req_tuser[0]),
      .rx_byte (req_tdata),
      .entry   (front_entry)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && can_push),
      .push_entry (front_entry),
      .can_push   (can_push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sfr_back #(.MAX_FRAME(MAX_FRAME)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_kind          (kind),
      .rsp_data_byte     (data_byte),
      .rsp_position      (position),
      .rsp_device_status (device_status),
      .rsp_frame_length  (frame_length)
   );

   assign rsp_tdata = {frame_length, device_status, position, data_byte};
   assign rsp_tuser = kind;

endmodule
